// ----- hdl/sha256_pkg.sv -----
package sha256_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos = 56;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic FuncAbsorb = 1'b0;
  localparam logic FuncFinish = 1'b1;

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_LOAD,
    CMD_ROUND,
    CMD_FOLD,
    CMD_INIT
  } sha_cmd_e_t;

  typedef struct packed {
    sha_cmd_e_t   op;
    logic [5:0]   pos;
    logic [7:0]   byte_val;
    logic [5:0]   round;
    logic         add_len;
  } sha_cmd_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ----- hdl/sha256_datapath.sv -----
module sha256_datapath (
  input  logic                 clk,
  input  sha256_pkg::sha_cmd_t cmd,
  input  logic                 rst,
  output logic [31:0]          hash_out [8]
);
  import sha256_pkg::*;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];
  logic [31:0] s0, s1, w_new, t1, t2, e, a;

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    a = v[0];
    e = v[4];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + RoundK[cmd.round] + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  // Message bytes go straight into the schedule window, big-endian within each word.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_WRITE: begin
        w[cmd.pos[5:2]][8*(3 - cmd.pos[1:0]) +: 8] <= cmd.byte_val;
      end
      CMD_LOAD: begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= h[i];
        end
      end
      CMD_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= w_new;
        for (int i = 1; i < 8; i++) begin
          if (i != 4) begin
            v[i] <= v[i-1];
          end
        end
        v[4] <= v[3] + t1;
        v[0] <= t1 + t2;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == CMD_INIT) begin
      for (int i = 0; i < 8; i++) begin
        h[i] <= InitHash[i];
      end
    end else if (cmd.op == CMD_FOLD) begin
      for (int i = 0; i < 8; i++) begin
        h[i] <= h[i] + v[i];
      end
    end
  end

  assign hash_out = h;

endmodule

// ----- hdl/sha256_control.sv -----
module sha256_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [7:0]           data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           word_index,
  output logic                 last_word,
  output sha256_pkg::sha_cmd_t cmd
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROUND, S_FOLD, S_PAD, S_EMIT
  } state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [6:0]  round;
  logic        finishing;
  logic        second;
  logic [2:0]  idx;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign word_index = idx;
  assign last_word = (idx == 3'd7);

  always_comb begin
    cmd = '0;
    cmd.op = CMD_NONE;
    cmd.round = round[5:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = CMD_WRITE;
          cmd.pos = fill;
          if (func == FuncAbsorb) begin
            cmd.byte_val = data_byte;
          end else begin
            cmd.byte_val = PadByte;
          end
        end
      end
      S_LOAD: cmd.op = CMD_LOAD;
      S_ROUND: cmd.op = CMD_ROUND;
      S_FOLD: cmd.op = CMD_FOLD;
      S_PAD: begin
        cmd.op = CMD_WRITE;
        cmd.pos = fill;
        if (fill >= 6'(LenPos) && !second) begin
          cmd.byte_val = bits[8*(7 - fill[2:0]) +: 8];
        end else begin
          cmd.byte_val = 8'h00;
        end
      end
      S_EMIT: begin
        if (out_ready && last_word) begin
          cmd.op = CMD_INIT;
        end
      end
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      bits <= '0;
      round <= '0;
      finishing <= 1'b0;
      second <= 1'b0;
      idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fill <= fill + 6'd1;
            if (func == FuncAbsorb) begin
              bits <= bits + 64'd8;
              if (fill == 6'd63) begin
                state <= S_LOAD;
              end
            end else begin
              finishing <= 1'b1;
              second <= (fill >= 6'(LenPos));
              if (fill == 6'd63) begin
                state <= S_LOAD;
              end else begin
                state <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          round <= round + 7'd1;
          if (round == 7'(Rounds - 1)) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (!finishing) begin
            state <= S_IDLE;
          end else if (second) begin
            second <= 1'b0;
            state <= S_PAD;
          end else begin
            state <= S_EMIT;
            idx <= '0;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (last_word) begin
              state <= S_IDLE;
              finishing <= 1'b0;
              second <= 1'b0;
              bits <= '0;
              fill <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken during digest output");
  assert property (@(posedge clk) disable iff (rst) (state == S_ROUND) |-> round < 7'd64)
    else $error("round counter overrun");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> $stable(idx))
    else $error("word index moved under stall");

endmodule

// ----- hdl/sha256_byte_stream_hasher_unit.sv -----
// Channel | Handshake          | Payload
// in      | in_valid/in_ready  | func, data_byte
// out     | out_valid/out_ready| digest_word, word_index, last_word
// An absorb writes one byte; every 64th byte starts a compression (load, rounds, fold).
// A finish pads one byte per cycle up to the block end, then compresses that block,
// and a second block is padded and compressed when 56 or more bytes were buffered.
// Eight digest words follow, one per cycle while out_ready is high; out stalls hold them.
// Synchronous reset restores the initial hash, zero length and an empty block.
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  sha_cmd_t    cmd;
  logic [31:0] hash_out [8];

  sha256_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
    .word_index(word_index), .last_word(last_word), .cmd(cmd)
  );

  sha256_datapath u_dp (.clk(clk), .cmd(cmd), .rst(rst), .hash_out(hash_out));

  assign digest_word = hash_out[word_index];

endmodule

// ----- sim/sha256_byte_stream_hasher_unit_tb.sv -----
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_unit_tb;
  import sha256_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } request_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  request_t     request_q[$];
  digest_beat_t digest_q[$];
  logic [31:0]  hash_state[8];
  logic [7:0]   msg_block[64];
  logic [5:0]   fill_count;
  logic [63:0]  length_bits;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_gap = 0;
  bit           quiet_mode = 1'b0;
  bit           hold_send = 1'b0;
  bit           in_accepted = 1'b0;

  sha256_byte_stream_hasher_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic fold_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
    fill_count = '0;
    length_bits = '0;
  endtask

  task automatic predict_request(request_t r);
    int unsigned pos;
    if (r.func == FuncAbsorb) begin
      msg_block[fill_count] = r.data_byte;
      length_bits += 64'd8;
      fill_count++;
      if (fill_count == 0) fold_block();
    end else begin
      pos = fill_count;
      msg_block[pos++] = PadByte;
      if (pos > LenPos) begin
        while (pos < BlockBytes) msg_block[pos++] = 8'h00;
        fold_block();
        pos = 0;
      end
      while (pos < LenPos) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[LenPos+i] = length_bits[63-8*i -: 8];
      fold_block();
      for (int i = 0; i < 8; i++) digest_q.push_back({hash_state[i], 3'(i), i == 7});
      restart_hash();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("error: %s got %h expected %h", what, got, want);
    error_count++;
  endtask

  task automatic add_message(int unsigned len, bit all_ones);
    for (int unsigned i = 0; i < len; i++) begin
      request_q.push_back({FuncAbsorb, all_ones ? 8'hff : 8'($urandom)});
    end
    request_q.push_back({FuncFinish, 8'($urandom)});
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_accepted) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0 && !hold_send) begin
          in_valid <= 1'b1;
          func <= request_q[0].func;
          data_byte <= request_q[0].data_byte;
          request_q.pop_front();
          if (!quiet_mode && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_mode && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    in_accepted = !rst && in_valid && in_ready;
    if (in_accepted) predict_request({func, data_byte});
    if (!rst && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", digest_word, 32'h0);
      end else begin
        if (digest_word !== digest_q[0].digest_word)
          report_mismatch("digest_word", digest_word, digest_q[0].digest_word);
        if (word_index !== digest_q[0].word_index)
          report_mismatch("word_index", 32'(word_index), 32'(digest_q[0].word_index));
        if (last_word !== digest_q[0].last_word)
          report_mismatch("last_word", 32'(last_word), 32'(digest_q[0].last_word));
        void'(digest_q.pop_front());
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sha256_byte_stream_hasher_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    restart_hash();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_message(0, 1'b0);
    add_message(3, 1'b1);
    request_q.push_back({FuncAbsorb, 8'h00});
    request_q.push_back({FuncFinish, 8'hff});
    request_q.push_back({FuncFinish, 8'h00});
    add_message(55, 1'b0);
    add_message(56, 1'b0);
    add_message(63, 1'b0);
    add_message(64, 1'b1);

    while (request_q.size() > 0 || in_valid) @(posedge clk);
    hold_send = 1'b1;
    while (digest_q.size() > 0) @(posedge clk);
    hold_send = 1'b0;

    for (int m = 0; m < 5; m++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      add_message(len, 1'b0);
    end
    while (request_q.size() > 0) @(posedge clk);
    quiet_mode = 1'b1;
    for (int m = 0; m < 4; m++) add_message($urandom_range(0, 12), 1'b0);
    while (request_q.size() > 0 || in_valid) @(posedge clk);
    while (digest_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("sha256_byte_stream_hasher_unit: match");
    end else begin
      $display("sha256_byte_stream_hasher_unit: mismatch");
    end
    $finish;
  end

endmodule
